// ----- src/spi_master_half_step_engine_top_assert.svh -----
// Assertion macros for the SPI half-step engine top level.
// No dependencies; included by the top level only.
`ifndef SPI_MASTER_HALF_STEP_ENGINE_TOP_ASSERT_SVH
`define SPI_MASTER_HALF_STEP_ENGINE_TOP_ASSERT_SVH

// same-cycle implication
`define SPI_MHS_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spi_mhs assertion failed");

// next-cycle implication
`define SPI_MHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spi_mhs assertion failed");

`endif

// ----- src/spi_mhs_pkg.sv -----
// Shared types and codes for the SPI half-step engine.
// No dependencies.
package spi_mhs_pkg;

    localparam int COUNT_W = 28;
    localparam int POS_W   = 32;
    localparam int TICK_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_IDLE_HIGH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_EDGE_PHASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD_TICKS = 2'd3;

    typedef struct packed {
        logic              clock_idle_high;
        logic              second_edge_phase;
        logic              msb_first;
        logic [TICK_W-1:0] half_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic wr_idle_clock;
        logic idle_clock;
    } cfg_evt_t;

    typedef struct packed {
        logic               mode;
        logic [COUNT_W-1:0] byte_count;
        logic               tx_enable;
        logic               rx_enable;
        logic [7:0]         tx_byte;
        logic               miso_level;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  total;
        logic [TICK_W-1:0] tick;
        logic              clock_level;
        logic              data_out_level;
        logic              select_level;
        logic [7:0]        receive_shift;
        logic              tx_en;
        logic              rx_en;
    } state_t;

    typedef struct packed {
        logic               sck_level;
        logic               mosi_level;
        logic               select_n;
        logic [7:0]         rx_byte;
        logic               rx_valid;
        logic [COUNT_W-1:0] tx_index;
        logic               done_res;
        logic               busy_res;
    } result_t;

endpackage

// ----- src/spi_mhs_if.sv -----
// Handshake channel interfaces: input items, result items, register writes.
// Depends on spi_mhs_pkg.
interface spi_mhs_item_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [spi_mhs_pkg::COUNT_W-1:0] byte_count;
    logic                            tx_enable;
    logic                            rx_enable;
    logic [7:0]                      tx_byte;
    logic                            miso_level;

    modport source (output valid, mode, byte_count, tx_enable, rx_enable, tx_byte,
                    miso_level, input ready);
    modport sink (input valid, mode, byte_count, tx_enable, rx_enable, tx_byte,
                  miso_level, output ready);
endinterface

interface spi_mhs_result_if;
    logic                            valid;
    logic                            ready;
    logic                            sck_level;
    logic                            mosi_level;
    logic                            select_n;
    logic [7:0]                      rx_byte;
    logic                            rx_valid;
    logic [spi_mhs_pkg::COUNT_W-1:0] tx_index;
    logic                            done_res;
    logic                            busy_res;

    modport source (output valid, sck_level, mosi_level, select_n, rx_byte, rx_valid,
                    tx_index, done_res, busy_res, input ready);
    modport sink (input valid, sck_level, mosi_level, select_n, rx_byte, rx_valid,
                  tx_index, done_res, busy_res, output ready);
endinterface

interface spi_mhs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [spi_mhs_pkg::CFG_IDX_W-1:0]  index;
    logic [spi_mhs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- src/spi_mhs_cfg.sv -----
// Configuration register file for the SPI half-step engine.
// Depends on spi_mhs_pkg and spi_mhs_cfg_if.
module spi_mhs_cfg (
    input  logic                clk,
    input  logic                rst_n,
    spi_mhs_cfg_if.sink         cfg,
    output spi_mhs_pkg::cfg_t     cfg_out,
    output spi_mhs_pkg::cfg_evt_t evt
);

    spi_mhs_pkg::cfg_t cfg_reg;
    logic              wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;
    assign cfg_out   = cfg_reg;

    assign evt.wr_idle_clock = wr && (cfg.index == spi_mhs_pkg::CFG_CLOCK_IDLE_HIGH);
    assign evt.idle_clock    = cfg.data[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clock_idle_high   <= 1'b0;
            cfg_reg.second_edge_phase <= 1'b0;
            cfg_reg.msb_first         <= 1'b1;
            cfg_reg.half_period_ticks <= spi_mhs_pkg::TICK_W'(1);
        end
        else if (wr)
        begin
            unique case (cfg.index)
                spi_mhs_pkg::CFG_CLOCK_IDLE_HIGH:   cfg_reg.clock_idle_high   <= cfg.data[0];
                spi_mhs_pkg::CFG_SECOND_EDGE_PHASE: cfg_reg.second_edge_phase <= cfg.data[0];
                spi_mhs_pkg::CFG_MSB_FIRST:         cfg_reg.msb_first         <= cfg.data[0];
                spi_mhs_pkg::CFG_HALF_PERIOD_TICKS: cfg_reg.half_period_ticks <= cfg.data;
                default: ;
            endcase
        end
    end

endmodule

// ----- src/spi_mhs_step.sv -----
// Next-state and result logic for one item: start handling, tick divider,
// and one SPI half-step. Depends on spi_mhs_pkg.
module spi_mhs_step (
    input  spi_mhs_pkg::cfg_t    cfg,
    input  spi_mhs_pkg::state_t  cur,
    input  spi_mhs_pkg::item_t   item,
    output spi_mhs_pkg::state_t  nxt,
    output spi_mhs_pkg::result_t res
);

    always_comb
    begin
        logic [spi_mhs_pkg::TICK_W-1:0] period;
        logic [spi_mhs_pkg::TICK_W-1:0] tick_inc;
        logic [spi_mhs_pkg::POS_W-1:0]  p;
        logic [spi_mhs_pkg::POS_W-1:0]  np;
        logic [2:0]                     idx;
        logic [2:0]                     bitpos;
        logic                           run;
        logic                           last;
        logic                           toggle;

        nxt          = cur;
        run          = 1'b0;
        res.rx_byte  = 8'h00;
        res.rx_valid = 1'b0;
        res.done_res = 1'b0;

        period   = (cfg.half_period_ticks == '0) ? spi_mhs_pkg::TICK_W'(1)
                                                 : cfg.half_period_ticks;
        tick_inc = cur.tick + spi_mhs_pkg::TICK_W'(1);

        if (item.mode == spi_mhs_pkg::MODE_START)
        begin
            // start is dropped while a transfer runs
            if (cur.total == '0)
            begin
                nxt.tx_en         = item.tx_enable;
                nxt.rx_en         = item.rx_enable;
                nxt.total         = {item.byte_count, 4'b0000} + spi_mhs_pkg::POS_W'(1);
                nxt.pos           = '0;
                nxt.tick          = '0;
                nxt.receive_shift = 8'h00;
                nxt.select_level  = 1'b0;
                run               = 1'b1;
            end
        end
        else if (cur.total != '0)
        begin
            nxt.tick = tick_inc;
            if (tick_inc >= period)
            begin
                nxt.tick = '0;
                run      = 1'b1;
            end
        end

        p      = nxt.pos;
        np     = p + spi_mhs_pkg::POS_W'(1);
        idx    = p[3:1];
        bitpos = cfg.msb_first ? (3'd7 - idx) : idx;
        last   = (np >= nxt.total);
        toggle = cfg.second_edge_phase ? !last : (np > spi_mhs_pkg::POS_W'(1));

        if (run)
        begin
            nxt.pos = np;
            if (toggle)
                nxt.clock_level = !nxt.clock_level;
            // odd positions sample, even positions drive
            if (nxt.rx_en && p[0])
            begin
                nxt.receive_shift[bitpos] = item.miso_level;
                if (p[3:0] == 4'hF)
                begin
                    res.rx_byte  = nxt.receive_shift;
                    res.rx_valid = 1'b1;
                end
            end
            if (nxt.tx_en && !p[0] && !last)
                nxt.data_out_level = item.tx_byte[bitpos];
            if (last)
            begin
                nxt.total        = '0;
                nxt.select_level = 1'b1;
                res.done_res     = 1'b1;
            end
        end

        res.sck_level  = nxt.clock_level;
        res.mosi_level = nxt.data_out_level;
        res.select_n   = nxt.select_level;
        res.tx_index   = (nxt.total != '0) ? nxt.pos[spi_mhs_pkg::POS_W-1:4] : '0;
        res.busy_res   = (nxt.total != '0);
    end

endmodule

// ----- src/spi_master_half_step_engine_top.sv -----
// SPI master half-step engine: channel registers, transfer state, result register.
// Depends on spi_mhs_pkg, spi_mhs_if.sv, spi_mhs_cfg, spi_mhs_step and the assert header.
//
// Usage:
//   items   - input channel. mode START begins a transfer of byte_count bytes and
//             runs the first half-step; mode TICK is one base time tick. tx_byte
//             must hold the byte at the tx_index of the previous result.
//   results - one result per item: pin levels after the item, rx byte events,
//             the next tx_index, done and busy flags.
//   cfg     - register writes (index 0..3), always ready. Write only while idle.
// Path: an item is registered at acceptance and its result is registered when the
// item advances, which waits while an untaken result holds the result register.
// Throughput: one item per cycle while results are taken; the half-step logic sits
// between the input register and the result/state registers.
// Receiver stall: the result register holds; the input register keeps one item,
// then items.ready drops until the result is taken.
// Reset: idle, select_n high, SCK low, registers at their defaults
// (msb first, one tick per half period).
`include "spi_master_half_step_engine_top_assert.svh"

module spi_master_half_step_engine_top (
    input  logic              clk,
    input  logic              rst_n,
    spi_mhs_item_if.sink      items,
    spi_mhs_result_if.source  results,
    spi_mhs_cfg_if.sink       cfg
);

    spi_mhs_pkg::cfg_t     cfg_cur;
    spi_mhs_pkg::cfg_evt_t cfg_evt;
    spi_mhs_pkg::item_t    item_reg;
    logic                  item_valid_reg;
    spi_mhs_pkg::state_t   state_reg;
    spi_mhs_pkg::state_t   state_next;
    spi_mhs_pkg::result_t  result_reg;
    spi_mhs_pkg::result_t  result_next;
    logic                  result_valid_reg;
    logic                  adv;
    logic                  take;

    spi_mhs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur),
        .evt     (cfg_evt)
    );

    spi_mhs_step u_step (
        .cfg  (cfg_cur),
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    assign adv         = item_valid_reg && (!result_valid_reg || results.ready);
    assign items.ready = !item_valid_reg || adv;
    assign take        = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (items.ready)
            item_valid_reg <= items.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.mode       <= items.mode;
            item_reg.byte_count <= items.byte_count;
            item_reg.tx_enable  <= items.tx_enable;
            item_reg.rx_enable  <= items.rx_enable;
            item_reg.tx_byte    <= items.tx_byte;
            item_reg.miso_level <= items.miso_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pos            <= '0;
            state_reg.total          <= '0;
            state_reg.tick           <= '0;
            state_reg.clock_level    <= 1'b0;
            state_reg.data_out_level <= 1'b0;
            state_reg.select_level   <= 1'b1;
            state_reg.receive_shift  <= 8'h00;
            state_reg.tx_en          <= 1'b0;
            state_reg.rx_en          <= 1'b0;
        end
        else if (adv)
            state_reg <= state_next;
        else if (cfg_evt.wr_idle_clock && (state_reg.total == '0))
            state_reg.clock_level <= cfg_evt.idle_clock;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (adv)
            result_valid_reg <= 1'b1;
        else if (results.ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            result_reg <= result_next;
    end

    assign results.valid      = result_valid_reg;
    assign results.sck_level  = result_reg.sck_level;
    assign results.mosi_level = result_reg.mosi_level;
    assign results.select_n   = result_reg.select_n;
    assign results.rx_byte    = result_reg.rx_byte;
    assign results.rx_valid   = result_reg.rx_valid;
    assign results.tx_index   = result_reg.tx_index;
    assign results.done_res   = result_reg.done_res;
    assign results.busy_res   = result_reg.busy_res;

    // select is low exactly while a transfer is open
    `SPI_MHS_ASSERT(a_select_tracks_busy, clk, rst_n, 1'b1, ((state_reg.total != '0) == !state_reg.select_level))
    `SPI_MHS_ASSERT(a_pos_below_total, clk, rst_n, (state_reg.total != '0), (state_reg.pos < state_reg.total))
    `SPI_MHS_ASSERT(a_rx_on_byte_edge, clk, rst_n, (adv && result_next.rx_valid), (state_next.pos[3:0] == 4'h0))
    `SPI_MHS_ASSERT_NEXT(a_done_goes_idle, clk, rst_n, (adv && result_next.done_res), (state_reg.total == '0))

endmodule

// ----- test/spi_mhs_checker.sv -----
`timescale 1ns / 100ps
// Checker for the SPI half-step engine: watches the item, result and register channels,
// predicts every result from its own copy of the engine state and compares field by field.
// Depends on spi_mhs_pkg and the channel interfaces in spi_mhs_if.sv.
module spi_mhs_checker (
    input  logic      clk,
    input  logic      rst_n,
    spi_mhs_item_if   items,
    spi_mhs_result_if results,
    spi_mhs_cfg_if    cfg,
    output int        fail_count,
    output int        outstanding
);
    import spi_mhs_pkg::*;

    // register copy
    logic        idle_high;
    logic        late_phase;
    logic        msb_order;
    logic [8:0]  half_ticks;

    // transfer copy
    logic [32:0] step_pos;
    logic [32:0] step_total;
    logic [8:0]  tick_cnt;
    logic        sck_lvl;
    logic        mosi_lvl;
    logic        sel_lvl;
    logic [7:0]  rx_shift;
    logic        tx_on;
    logic        rx_on;

    // per-transaction events
    logic [7:0]  evt_rx_byte;
    logic        evt_rx_valid;
    logic        evt_done;

    result_t     predicted_pins [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 50)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_CLOCK_IDLE_HIGH:
            begin
                idle_high = val[0];
                if (step_total == 33'd0)
                    sck_lvl = val[0];
            end
            CFG_SECOND_EDGE_PHASE: late_phase = val[0];
            CFG_MSB_FIRST:         msb_order  = val[0];
            CFG_HALF_PERIOD_TICKS: half_ticks = val[8:0];
            default: ;
        endcase
    endtask

    task automatic run_half_step(input logic [7:0] txb, input logic miso);
        logic [32:0] p;
        logic [32:0] np;
        logic [2:0]  idx;
        logic [2:0]  bit_sel;
        logic        sample;
        p       = step_pos;
        idx     = p[3:1];
        bit_sel = msb_order ? (3'd7 - idx) : idx;
        sample  = p[0];
        np      = p + 33'd1;
        step_pos = np;

        if ((late_phase && np < step_total) || (!late_phase && np > 33'd1))
            sck_lvl = ~sck_lvl;

        if (rx_on && sample)
        begin
            rx_shift[bit_sel] = miso;
            if (p[3:0] == 4'hF)
            begin
                evt_rx_byte  = rx_shift;
                evt_rx_valid = 1'b1;
            end
        end

        // last step never drives MOSI: its byte would be past the end
        if (tx_on && !sample && np < step_total)
            mosi_lvl = txb[bit_sel];

        if (np >= step_total)
        begin
            step_total = 33'd0;
            sel_lvl    = 1'b1;
            evt_done   = 1'b1;
        end
    endtask

    task automatic predict_result(input item_t it, output result_t r);
        logic [8:0] eff_period;
        eff_period   = (half_ticks == 9'd0) ? 9'd1 : half_ticks;
        evt_rx_byte  = 8'd0;
        evt_rx_valid = 1'b0;
        evt_done     = 1'b0;

        if (it.mode == MODE_START)
        begin
            // start while busy is dropped
            if (step_total == 33'd0)
            begin
                tx_on      = it.tx_enable;
                rx_on      = it.rx_enable;
                step_total = {1'b0, it.byte_count, 4'b0000} + 33'd1;
                step_pos   = 33'd0;
                tick_cnt   = 9'd0;
                rx_shift   = 8'd0;
                sel_lvl    = 1'b0;
                run_half_step(it.tx_byte, it.miso_level);
            end
        end
        else if (step_total != 33'd0)
        begin
            tick_cnt = tick_cnt + 9'd1;
            if (tick_cnt >= eff_period)
            begin
                tick_cnt = 9'd0;
                run_half_step(it.tx_byte, it.miso_level);
            end
        end

        r.sck_level  = sck_lvl;
        r.mosi_level = mosi_lvl;
        r.select_n   = sel_lvl;
        r.rx_byte    = evt_rx_byte;
        r.rx_valid   = evt_rx_valid;
        r.tx_index   = (step_total != 33'd0) ? step_pos[31:4] : '0;
        r.done_res   = evt_done;
        r.busy_res   = (step_total != 33'd0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        result_t want;
        if (!rst_n)
        begin
            idle_high   = 1'b0;
            late_phase  = 1'b0;
            msb_order   = 1'b1;
            half_ticks  = 9'd1;
            step_pos    = 33'd0;
            step_total  = 33'd0;
            tick_cnt    = 9'd0;
            sck_lvl     = 1'b0;
            mosi_lvl    = 1'b0;
            sel_lvl     = 1'b1;
            rx_shift    = 8'd0;
            tx_on       = 1'b0;
            rx_on       = 1'b0;
            predicted_pins.delete();
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                apply_write(cfg.index, cfg.data);

            // retire before predicting, so a result can never match its own item
            if (results.valid && results.ready)
            begin
                if (predicted_pins.size() == 0)
                begin
                    report_mismatch("result transaction with no item pending");
                end
                else
                begin
                    want = predicted_pins.pop_front();
                    check_field("sck_level", 32'(want.sck_level), 32'(results.sck_level));
                    check_field("mosi_level", 32'(want.mosi_level), 32'(results.mosi_level));
                    check_field("select_n", 32'(want.select_n), 32'(results.select_n));
                    check_field("rx_byte", 32'(want.rx_byte), 32'(results.rx_byte));
                    check_field("rx_valid", 32'(want.rx_valid), 32'(results.rx_valid));
                    check_field("tx_index", 32'(want.tx_index), 32'(results.tx_index));
                    check_field("done_res", 32'(want.done_res), 32'(results.done_res));
                    check_field("busy_res", 32'(want.busy_res), 32'(results.busy_res));
                end
            end

            if (items.valid && items.ready)
            begin
                it.mode       = items.mode;
                it.byte_count = items.byte_count;
                it.tx_enable  = items.tx_enable;
                it.rx_enable  = items.rx_enable;
                it.tx_byte    = items.tx_byte;
                it.miso_level = items.miso_level;
                predict_result(it, want);
                predicted_pins.push_back(want);
            end

            outstanding = predicted_pins.size();
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// Top of the SPI half-step engine testbench: clock, reset, stimulus and the verdict.
// Depends on spi_mhs_pkg, spi_mhs_if.sv, spi_master_half_step_engine_top, spi_mhs_checker.
module testbench;
    import spi_mhs_pkg::*;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    spi_mhs_item_if   items_ch ();
    spi_mhs_result_if results_ch ();
    spi_mhs_cfg_if    cfg_ch ();

    int                 fail_count;
    int                 outstanding;
    bit                 calm = 1'b0;
    bit                 churn = 1'b1;
    int                 stall_left = 0;
    int                 done_total = 0;
    logic [COUNT_W-1:0] last_tx_index = '0;
    int                 cur_period = 1;
    int                 items_sent = 0;

    spi_master_half_step_engine_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch),
        .cfg     (cfg_ch)
    );

    spi_mhs_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items_ch),
        .results     (results_ch),
        .cfg         (cfg_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tx_byte has to follow the index the block asked for last
    always @(posedge clk)
    begin
        if (results_ch.valid && results_ch.ready)
        begin
            last_tx_index <= results_ch.tx_index;
            if (results_ch.done_res)
                done_total <= done_total + 1;
        end
    end

    // result side back-pressure in short bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            results_ch.ready = 1'b0;
        end
        else if (!calm && churn && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            results_ch.ready = 1'b0;
        end
        else
        begin
            results_ch.ready = 1'b1;
        end
    end

    function automatic item_t random_item(input logic mode);
        item_t it;
        it.mode       = mode;
        it.byte_count = COUNT_W'($urandom);
        it.tx_enable  = 1'($urandom);
        it.rx_enable  = 1'($urandom);
        it.tx_byte    = 8'($urandom);
        it.miso_level = 1'($urandom);
        return it;
    endfunction

    task automatic push_item(input item_t it);
        @(negedge clk);
        if (!calm && churn && $urandom_range(0, 3) == 0)
        begin
            items_ch.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        items_ch.mode       = it.mode;
        items_ch.byte_count = it.byte_count;
        items_ch.tx_enable  = it.tx_enable;
        items_ch.rx_enable  = it.rx_enable;
        items_ch.tx_byte    = it.tx_byte;
        items_ch.miso_level = it.miso_level;
        items_ch.valid      = 1'b1;
        @(posedge clk);
        while (!items_ch.ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        cfg_ch.valid = 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // drain: every result back, plus the pipeline depth
    task automatic settle();
        @(negedge clk);
        items_ch.valid = 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apply_config(input bit idle_high, input bit late, input bit msb,
                                input logic [8:0] half);
        settle();
        write_reg(CFG_CLOCK_IDLE_HIGH, {8'd0, idle_high});
        write_reg(CFG_SECOND_EDGE_PHASE, {8'd0, late});
        write_reg(CFG_MSB_FIRST, {8'd0, msb});
        write_reg(CFG_HALF_PERIOD_TICKS, half);
        cur_period = (half == 9'd0) ? 1 : int'(half);
    endtask

    // one transfer: start, then ticks until its done comes back;
    // stray starts are only thrown in while the transfer surely still runs
    task automatic run_transfer(input logic [COUNT_W-1:0] count, input bit txen,
                                input bit rxen, input bit poke);
        logic [7:0] pattern [8];
        int         done_mark;
        int         ticks;
        int         span;
        item_t      it;
        foreach (pattern[i]) pattern[i] = 8'($urandom);
        done_mark = done_total;
        span      = 16 * int'(count) * cur_period;
        it = random_item(MODE_START);
        it.byte_count = count;
        it.tx_enable  = txen;
        it.rx_enable  = rxen;
        it.tx_byte    = pattern[0];
        push_item(it);
        items_sent++;
        ticks = 0;
        while (done_total == done_mark)
        begin
            if (ticks < span && ((poke && ticks == 0) || $urandom_range(0, 9) == 0))
            begin
                it = random_item(MODE_START);
                if (poke)
                    it.byte_count = '1;
                push_item(it);
            end
            it = random_item(MODE_TICK);
            it.tx_byte = pattern[last_tx_index[2:0]];
            push_item(it);
            ticks++;
            items_sent++;
        end
    endtask

    initial
    begin
        int                 ph;
        int                 budget;
        int                 phase_start;
        int                 half;
        int                 pick;
        logic [COUNT_W-1:0] count;
        item_t              it;
        items_ch.valid      = 1'b0;
        items_ch.mode       = MODE_TICK;
        items_ch.byte_count = '0;
        items_ch.tx_enable  = 1'b0;
        items_ch.rx_enable  = 1'b0;
        items_ch.tx_byte    = 8'd0;
        items_ch.miso_level = 1'b0;
        results_ch.ready    = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_CLOCK_IDLE_HIGH;
        cfg_ch.data         = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed: defaults, tick while idle, empty transfer, one byte with a
        // start arriving mid-transfer
        apply_config(1'b0, 1'b0, 1'b1, 9'd1);
        it = '1;
        it.mode = MODE_TICK;
        push_item(it);
        run_transfer('0, 1'b1, 1'b1, 1'b0);
        run_transfer(COUNT_W'(1), 1'b1, 1'b1, 1'b1);

        for (ph = 0; items_sent < 1300; ph++)
        begin
            case (ph)
                1:       half = 0;
                2:       half = 500;
                5:       half = 16;
                default: half = $urandom_range(1, 3);
            endcase
            if (ph < 8)
                apply_config(ph[0], ph[1], ph[2], 9'(half));
            else
                apply_config(1'($urandom), 1'($urandom), 1'($urandom), 9'(half));
            calm  = (items_sent >= 1150);
            churn = ($urandom_range(0, 3) != 0);

            budget      = (half == 500) ? 30 : 150;
            phase_start = items_sent;
            while (items_sent - phase_start < budget)
            begin
                pick = $urandom_range(0, 9);
                if (half == 500)
                    count = '0;
                else if (half == 16)
                    count = COUNT_W'($urandom_range(0, 1));
                else if (pick == 0)
                    count = '0;
                else if (pick <= 5)
                    count = COUNT_W'(1);
                else if (pick <= 8)
                    count = COUNT_W'(2);
                else
                    count = COUNT_W'(3);
                run_transfer(count, $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                             1'b0);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) push_item(random_item(MODE_TICK));
            end
        end

        // largest count last: it never finishes, so nothing may follow it
        calm = 1'b1;
        it = random_item(MODE_START);
        it.byte_count = '1;
        push_item(it);
        repeat (40) push_item(random_item(MODE_TICK));
        settle();

        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/spi_mhs_pkg.sv
src/spi_mhs_if.sv
src/spi_mhs_cfg.sv
src/spi_mhs_step.sv
src/spi_master_half_step_engine_top.sv
test/spi_mhs_checker.sv
test/testbench.sv
